// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, muted while reset is high.
`define MBPS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define MBPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/mbps_pkg.sv -----
package mbps_pkg;

   // fixed field widths
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 64;
   localparam int PATTERN_BYTES = 16;
   localparam int OUT_OFFSET_W  = 32;
   localparam int COUNT_W       = 32;
   localparam int CAPACITY_W    = 16;
   localparam int PLEN_W        = 5;
   localparam int MODE_W        = 2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LOW  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_HIGH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MUST_MATCH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LEN  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LIST_CAP     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SEARCH_MODE  = 3'd5;

   // search modes (any other code behaves as both)
   localparam logic [MODE_W-1:0] MODE_MASKED = 2'd0;
   localparam logic [MODE_W-1:0] MODE_EXACT  = 2'd1;

   // result kinds
   localparam logic KIND_MATCH = 1'b0;
   localparam logic KIND_DONE  = 1'b1;

   // per-cell compare outcome
   typedef struct packed {
      logic exact_bad;
      logic mask_bad;
   } cell_cmp_type;

   // one item's pending results, handed to the emitter
   typedef struct packed {
      logic                    masked_hit;
      logic                    exact_hit;
      logic                    done;
      logic [OUT_OFFSET_W-1:0] start;
   } rec_type;

endpackage

// ----- rtl/core/mbps_cell.sv -----
module mbps_cell #(
   parameter int INDEX = 0,
   parameter int LEN_W = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 shift_en,
   input  logic                                 clear,
   input  logic [7:0]                           din,
   input  logic [LEN_W-1:0]                     len,
   input  logic [8*mbps_pkg::PATTERN_BYTES-1:0] pattern,
   input  logic [mbps_pkg::PATTERN_BYTES-1:0]   must,
   output logic [7:0]                           byte_q,
   output mbps_pkg::cell_cmp_type               cmp
);
   import mbps_pkg::*;

   logic [7:0]       byte_ff;
   logic [7:0]       byte_in;
   logic [LEN_W-1:0] pidx;
   logic [3:0]       pidx4;
   logic             active;
   logic [7:0]       pbyte;
   logic             pmust;
   logic             neq;

   // this cell lines up with pattern byte len-1-INDEX
   always_comb begin
      active = (32'(len) > INDEX);
      pidx   = len - LEN_W'(1) - LEN_W'(INDEX);
      pidx4  = 4'(pidx);
      if (32'(pidx) < PATTERN_BYTES) begin
         pbyte = pattern[8*pidx4 +: 8];
         pmust = must[pidx4];
      end else begin
         pbyte = 8'd0;
         pmust = 1'b0;
      end
      // compare against the byte that enters this cell now
      neq           = (din != pbyte);
      cmp.exact_bad = active && neq;
      cmp.mask_bad  = active && neq && pmust;
   end

   always_comb begin
      byte_in = byte_ff;
      if (shift_en) begin
         byte_in = clear ? 8'd0 : din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'd0;
      end else begin
         byte_ff <= byte_in;
      end
   end

   assign byte_q = byte_ff;

endmodule

// ----- rtl/core/mbps_emit.sv -----
module mbps_emit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  mbps_pkg::rec_type                   rec_in,
   input  logic [mbps_pkg::CAPACITY_W-1:0]     list_capacity,
   input  logic                                rsp_stall,
   output logic                                load_ok,
   output logic                                rsp_valid,
   output logic                                rsp_result_kind,
   output logic [mbps_pkg::OUT_OFFSET_W-1:0]   rsp_match_offset,
   output logic [mbps_pkg::COUNT_W-1:0]        rsp_match_number,
   output logic                                rsp_fits_in_list,
   output logic                                rsp_by_exact_compare,
   output logic [mbps_pkg::COUNT_W-1:0]        rsp_total_matches,
   output logic                                rsp_last_of_run
);
   import mbps_pkg::*;

   rec_type                 rec_ff, rec_in_q;
   logic [COUNT_W-1:0]      cnt_ff, cnt_in;
   logic                    vld_ff, vld_in;
   logic                    kind_ff, kind_in;
   logic [OUT_OFFSET_W-1:0] off_ff, off_in;
   logic [COUNT_W-1:0]      num_ff, num_in;
   logic                    fits_ff, fits_in;
   logic                    exact_ff, exact_in;
   logic [COUNT_W-1:0]      total_ff, total_in;
   logic                    last_ff, last_in;
   logic                    busy, out_free, emit, last;
   logic [COUNT_W-1:0]      cnt_inc;

   always_comb begin
      busy     = rec_ff.masked_hit | rec_ff.exact_hit | rec_ff.done;
      out_free = !vld_ff || !rsp_stall;
      emit     = busy && out_free;
      if (rec_ff.masked_hit) begin
         last = !(rec_ff.exact_hit | rec_ff.done);
      end else if (rec_ff.exact_hit) begin
         last = !rec_ff.done;
      end else begin
         last = 1'b1;
      end
      load_ok = !busy || (emit && last);
      cnt_inc = (cnt_ff == '1) ? cnt_ff : cnt_ff + COUNT_W'(1);
   end

   always_comb begin
      rec_in_q = rec_ff;
      cnt_in   = cnt_ff;
      vld_in   = vld_ff && rsp_stall;
      kind_in  = kind_ff;
      off_in   = off_ff;
      num_in   = num_ff;
      fits_in  = fits_ff;
      exact_in = exact_ff;
      total_in = total_ff;
      last_in  = last_ff;
      if (emit) begin
         vld_in  = 1'b1;
         last_in = last;
         if (rec_ff.masked_hit || rec_ff.exact_hit) begin
            kind_in  = KIND_MATCH;
            off_in   = rec_ff.start;
            num_in   = cnt_ff;
            fits_in  = (cnt_ff < COUNT_W'(list_capacity));
            exact_in = !rec_ff.masked_hit;
            total_in = '0;
            cnt_in   = cnt_inc;
            if (rec_ff.masked_hit) begin
               rec_in_q.masked_hit = 1'b0;
            end else begin
               rec_in_q.exact_hit = 1'b0;
            end
         end else begin
            kind_in        = KIND_DONE;
            off_in         = '0;
            num_in         = '0;
            fits_in        = 1'b0;
            exact_in       = 1'b0;
            total_in       = cnt_ff;
            cnt_in         = '0;
            rec_in_q.done  = 1'b0;
         end
      end
      if (load) begin
         rec_in_q = rec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff <= '0;
         cnt_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         rec_ff <= rec_in_q;
         cnt_ff <= cnt_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      off_ff   <= off_in;
      num_ff   <= num_in;
      fits_ff  <= fits_in;
      exact_ff <= exact_in;
      total_ff <= total_in;
      last_ff  <= last_in;
   end

   assign rsp_valid            = vld_ff;
   assign rsp_result_kind      = kind_ff;
   assign rsp_match_offset     = off_ff;
   assign rsp_match_number     = num_ff;
   assign rsp_fits_in_list     = fits_ff;
   assign rsp_by_exact_compare = exact_ff;
   assign rsp_total_matches    = total_ff;
   assign rsp_last_of_run      = last_ff;

endmodule

// ----- rtl/core/masked_byte_pattern_scanner_top.sv -----
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/req_stall | data_byte, region_end
// rsp     | out       | rsp_valid/rsp_stall | kind, offset, number, fits, exact, total, last
// csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata (ready always high)
//
// An item is compared in the cycle it is accepted; its results go through the record
// register, then the output register. Throughput is one item per cycle while each item
// makes one result at most and rsp_stall is low; extra results hold the input until sent.
// Items with no result pass without touching the output side.
// Reset (synchronous) clears window, counters and config to their defaults.
// rsp_stall only holds the output register; the input stalls once results back up.
module masked_byte_pattern_scanner_top #(
   parameter int MAX_PATTERN_BYTES = 16,
   parameter int OFFSET_BITS       = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // input items
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_region_end,
   // result items
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_result_kind,
   output logic [mbps_pkg::OUT_OFFSET_W-1:0]   rsp_match_offset,
   output logic [mbps_pkg::COUNT_W-1:0]        rsp_match_number,
   output logic                                rsp_fits_in_list,
   output logic                                rsp_by_exact_compare,
   output logic [mbps_pkg::COUNT_W-1:0]        rsp_total_matches,
   output logic                                rsp_last_of_run,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mbps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mbps_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mbps_pkg::*;

   // window length fits 0..MAX_PATTERN_BYTES
   localparam int LEN_W    = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int OFF_WIDE = (OFFSET_BITS > OUT_OFFSET_W) ? OFFSET_BITS : OUT_OFFSET_W;

   // ---------------- config registers ----------------
   logic [63:0]            pat_lo_ff, pat_hi_ff;
   logic [15:0]            must_ff;
   logic [PLEN_W-1:0]      plen_ff;
   logic [CAPACITY_W-1:0]  cap_ff;
   logic [MODE_W-1:0]      mode_ff;
   logic                   csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff <= '0;
         pat_hi_ff <= '0;
         must_ff   <= 16'hFFFF;
         plen_ff   <= PLEN_W'(1);
         cap_ff    <= '0;
         mode_ff   <= MODE_MASKED;
      end else if (csr_wr) begin
         case (csr_index)
            REG_PATTERN_LOW:  pat_lo_ff <= csr_wdata;
            REG_PATTERN_HIGH: pat_hi_ff <= csr_wdata;
            REG_MUST_MATCH:   must_ff   <= csr_wdata[15:0];
            REG_PATTERN_LEN:  plen_ff   <= csr_wdata[PLEN_W-1:0];
            REG_LIST_CAP:     cap_ff    <= csr_wdata[CAPACITY_W-1:0];
            REG_SEARCH_MODE:  mode_ff   <= csr_wdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // effective length: zero acts as one, capped at the window depth
   logic [LEN_W-1:0] len_cl;
   always_comb begin
      if (plen_ff == '0) begin
         len_cl = LEN_W'(1);
      end else if (32'(plen_ff) > MAX_PATTERN_BYTES) begin
         len_cl = LEN_W'(MAX_PATTERN_BYTES);
      end else begin
         len_cl = LEN_W'(plen_ff);
      end
   end

   // ---------------- accept / scan state ----------------
   logic                   load_ok, accept;
   logic [LEN_W-1:0]       fill_ff, fill_in, fill_next;
   logic [OFFSET_BITS-1:0] seen_ff, seen_in;

   assign req_stall = !load_ok;
   assign accept    = req_valid && load_ok;

   // fill count as it stands after this byte enters
   assign fill_next = (32'(fill_ff) >= MAX_PATTERN_BYTES) ? fill_ff : fill_ff + LEN_W'(1);

   always_comb begin
      fill_in = fill_ff;
      seen_in = seen_ff;
      if (accept) begin
         fill_in = req_region_end ? '0 : fill_next;
         seen_in = req_region_end ? '0 : seen_ff + OFFSET_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         seen_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         seen_ff <= seen_in;
      end
   end

   // ---------------- window cells ----------------
   // cell 0 holds the newest byte; each cell passes its byte to the next one
   logic [7:0]                 win_q [MAX_PATTERN_BYTES];
   cell_cmp_type               cmp_q [MAX_PATTERN_BYTES];
   logic [MAX_PATTERN_BYTES-1:0] exact_bad_v, mask_bad_v;
   logic [8*PATTERN_BYTES-1:0] pattern;

   assign pattern = {pat_hi_ff, pat_lo_ff};

   for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cell
      logic [7:0] din;
      if (j == 0) begin : g_head
         assign din = req_data_byte;
      end else begin : g_link
         assign din = win_q[j-1];
      end
      mbps_cell #(
         .INDEX (j),
         .LEN_W (LEN_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (accept),
         .clear    (req_region_end),
         .din      (din),
         .len      (len_cl),
         .pattern  (pattern),
         .must     (must_ff),
         .byte_q   (win_q[j]),
         .cmp      (cmp_q[j])
      );
      assign exact_bad_v[j] = cmp_q[j].exact_bad;
      assign mask_bad_v[j]  = cmp_q[j].mask_bad;
   end

   // ---------------- item record ----------------
   logic                   cmp_live;
   logic [OFFSET_BITS-1:0] start_off;
   logic [OFF_WIDE-1:0]    start_wide;
   rec_type                rec;

   always_comb begin
      cmp_live       = (fill_next >= len_cl);
      start_off      = seen_ff - OFFSET_BITS'(len_cl - LEN_W'(1));
      start_wide     = OFF_WIDE'(start_off);
      rec.masked_hit = cmp_live && (mode_ff != MODE_EXACT) && !(|mask_bad_v);
      rec.exact_hit  = cmp_live && (mode_ff != MODE_MASKED) && !(|exact_bad_v);
      rec.done       = req_region_end;
      rec.start      = start_wide[OUT_OFFSET_W-1:0];
   end

   // ---------------- result sequencing ----------------
   mbps_emit u_emit (
      .clock                (clock),
      .reset                (reset),
      .load                 (accept),
      .rec_in               (rec),
      .list_capacity        (cap_ff),
      .rsp_stall            (rsp_stall),
      .load_ok              (load_ok),
      .rsp_valid            (rsp_valid),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_match_offset     (rsp_match_offset),
      .rsp_match_number     (rsp_match_number),
      .rsp_fits_in_list     (rsp_fits_in_list),
      .rsp_by_exact_compare (rsp_by_exact_compare),
      .rsp_total_matches    (rsp_total_matches),
      .rsp_last_of_run      (rsp_last_of_run)
   );

endmodule

// ----- rtl/core/mbps_checker.sv -----
`include "assert_macros.svh"

module mbps_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_result_kind,
   input logic [mbps_pkg::OUT_OFFSET_W-1:0] rsp_match_offset,
   input logic [mbps_pkg::COUNT_W-1:0]      rsp_match_number,
   input logic                              rsp_fits_in_list,
   input logic                              rsp_by_exact_compare,
   input logic [mbps_pkg::COUNT_W-1:0]      rsp_total_matches,
   input logic                              rsp_last_of_run
);
   import mbps_pkg::*;

   // held result stays put
   property p_rsp_hold;
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_match_offset) && $stable(rsp_match_number)
         && $stable(rsp_fits_in_list) && $stable(rsp_by_exact_compare)
         && $stable(rsp_total_matches) && $stable(rsp_last_of_run);
   endproperty

   // a done item always closes its run
   property p_done_last;
      rsp_valid && (rsp_result_kind == KIND_DONE) |->
         rsp_last_of_run && !rsp_fits_in_list && (rsp_match_number == '0);
   endproperty

   // list capacity is 16 bits, so a fitting match number is small
   property p_fits_range;
      rsp_valid && rsp_fits_in_list |->
         (rsp_result_kind == KIND_MATCH) && (rsp_match_number[31:16] == '0);
   endproperty

   `MBPS_ASSERT(a_rsp_hold, clock, reset, p_rsp_hold, "rsp item changed while stalled")

   // nothing comes out right after reset
   `MBPS_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "rsp valid after reset")

   `MBPS_ASSERT(a_done_last, clock, reset, p_done_last, "done item malformed")

   `MBPS_ASSERT(a_fits_range, clock, reset, p_fits_range, "fits flag on out-of-range number")

endmodule

bind masked_byte_pattern_scanner_top mbps_checker u_mbps_checker (.*);

// ----- bench/tb_masked_byte_pattern_scanner_top.sv -----
module tb_masked_byte_pattern_scanner_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mbps_pkg::*;

   // modes the package leaves unnamed: 2 runs both compares, 3 behaves the same
   localparam logic [MODE_W-1:0]      MODE_BOTH     = 2'd2;
   localparam logic [MODE_W-1:0]      MODE_BOTH_ALT = 2'd3;
   // index past the register file, a write there must change nothing
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED    = 3'd6;

   localparam int DRAIN_CYCLES     = 8;    // quiet cycles after the last result
   localparam int LONG_HOLD_CYCLES = 150;  // output hold used to back up the block
   localparam int MAX_REPORTS      = 10;

   // one result item, fields at port widths
   typedef struct packed {
      logic                    result_kind;
      logic [OUT_OFFSET_W-1:0] match_offset;
      logic [COUNT_W-1:0]      match_number;
      logic                    fits_in_list;
      logic                    by_exact_compare;
      logic [COUNT_W-1:0]      total_matches;
      logic                    last_of_run;
   } scan_result_type;

   // ---------------------------------------------------------------------------------
   // clock, reset, DUT
   // ---------------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #4 clock = ~clock;

   logic                    req_valid      = 1'b0;
   logic                    req_stall;
   logic [7:0]              req_data_byte  = 8'h00;
   logic                    req_region_end = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall      = 1'b0;
   logic                    rsp_result_kind;
   logic [OUT_OFFSET_W-1:0] rsp_match_offset;
   logic [COUNT_W-1:0]      rsp_match_number;
   logic                    rsp_fits_in_list;
   logic                    rsp_by_exact_compare;
   logic [COUNT_W-1:0]      rsp_total_matches;
   logic                    rsp_last_of_run;
   logic                    csr_valid      = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index      = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata      = '0;

   masked_byte_pattern_scanner_top i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_region_end       (req_region_end),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_match_offset     (rsp_match_offset),
      .rsp_match_number     (rsp_match_number),
      .rsp_fits_in_list     (rsp_fits_in_list),
      .rsp_by_exact_compare (rsp_by_exact_compare),
      .rsp_total_matches    (rsp_total_matches),
      .rsp_last_of_run      (rsp_last_of_run),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // ---------------------------------------------------------------------------------
   // scanner model: shadow registers and scan state, reset values
   // ---------------------------------------------------------------------------------
   logic [63:0]           cfg_pattern_low  = '0;
   logic [63:0]           cfg_pattern_high = '0;
   logic [15:0]           cfg_must_match   = 16'hFFFF;
   logic [PLEN_W-1:0]     cfg_len          = 5'd1;
   logic [CAPACITY_W-1:0] cfg_capacity     = '0;
   logic [MODE_W-1:0]     cfg_mode         = MODE_MASKED;

   logic [7:0]            window [PATTERN_BYTES] = '{default: 8'h00};  // newest in [0]
   int                    window_fill = 0;
   logic [31:0]           bytes_seen  = '0;
   logic [COUNT_W-1:0]    match_count = '0;

   scan_result_type       pending_results [$];

   int mismatch_count     = 0;
   int results_checked    = 0;
   int match_results_seen = 0;
   int done_results_seen  = 0;
   int items_sent         = 0;

   // idling controls, set per phase
   int idle_pct      = 0;
   int stall_pct     = 0;
   int hold_requests = 0;

   // Shift one byte in and queue the results it causes: masked hit first, then exact,
   // then the region total when this byte ends the region.
   function automatic void scan_predict(input logic [7:0] data, input logic region_end);
      int              len;
      int              i;
      bit              masked_ok;
      bit              exact_ok;
      bit              hit;
      logic [127:0]    pattern;
      logic [31:0]     start;
      scan_result_type r;
      scan_result_type batch [$];

      len = int'(cfg_len);
      if (len == 0) len = 1;
      if (len > PATTERN_BYTES) len = PATTERN_BYTES;
      pattern = {cfg_pattern_high, cfg_pattern_low};

      for (i = PATTERN_BYTES - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = data;
      if (window_fill < PATTERN_BYTES) window_fill++;

      if (window_fill >= len) begin
         masked_ok = 1'b1;
         exact_ok  = 1'b1;
         start     = bytes_seen - 32'(len - 1);
         for (i = 0; i < len; i++) begin
            if (window[len-1-i] != pattern[8*i +: 8]) begin
               exact_ok = 1'b0;
               if (cfg_must_match[i]) masked_ok = 1'b0;
            end
         end
         for (int pass = 0; pass < 2; pass++) begin
            hit = (pass == 0) ? (cfg_mode != MODE_EXACT && masked_ok)
                              : (cfg_mode != MODE_MASKED && exact_ok);
            if (hit) begin
               r                  = '0;
               r.result_kind      = KIND_MATCH;
               r.match_offset     = start;
               r.match_number     = match_count;
               r.fits_in_list     = (match_count < cfg_capacity);
               r.by_exact_compare = (pass == 1);
               batch.push_back(r);
               if (match_count != '1) match_count++;   // count saturates
            end
         end
      end

      bytes_seen++;

      if (region_end) begin
         r               = '0;
         r.result_kind   = KIND_DONE;
         r.total_matches = match_count;
         batch.push_back(r);
         window      = '{default: 8'h00};
         window_fill = 0;
         bytes_seen  = '0;
         match_count = '0;
      end

      if (batch.size() != 0) batch[batch.size()-1].last_of_run = 1'b1;
      foreach (batch[k]) pending_results.push_back(batch[k]);
   endfunction

   // register writes take effect at the accepting edge
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            REG_PATTERN_LOW:  cfg_pattern_low  = csr_wdata;
            REG_PATTERN_HIGH: cfg_pattern_high = csr_wdata;
            REG_MUST_MATCH:   cfg_must_match   = csr_wdata[15:0];
            REG_PATTERN_LEN:  cfg_len          = csr_wdata[PLEN_W-1:0];
            REG_LIST_CAP:     cfg_capacity     = csr_wdata[CAPACITY_W-1:0];
            REG_SEARCH_MODE:  cfg_mode         = csr_wdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // every accepted input item feeds the model
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) scan_predict(req_data_byte, req_region_end);
   end

   // ---------------------------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------------------------
   function automatic void note_failure(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("[%0t] result %0d: %s expected %h got %h",
                  $realtime, results_checked, what, want, got);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) note_failure(name, want, got);
   endfunction

   always @(posedge clock) begin
      scan_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            note_failure("unexpected item, kind", 32'h0, 32'(rsp_result_kind));
         end else begin
            want = pending_results.pop_front();
            check_field("result_kind",      32'(want.result_kind),      32'(rsp_result_kind));
            check_field("match_offset",     want.match_offset,          rsp_match_offset);
            check_field("match_number",     want.match_number,          rsp_match_number);
            check_field("fits_in_list",     32'(want.fits_in_list),     32'(rsp_fits_in_list));
            check_field("by_exact_compare", 32'(want.by_exact_compare),
                        32'(rsp_by_exact_compare));
            check_field("total_matches",    want.total_matches,         rsp_total_matches);
            check_field("last_of_run",      32'(want.last_of_run),      32'(rsp_last_of_run));
         end
         results_checked++;
         if (rsp_result_kind == KIND_DONE) done_results_seen++;
         else match_results_seen++;
      end
   end

   // Output stall: random per cycle at stall_pct, or a long hold when the test asks.
   // The hold is counted here so the sender can keep pushing items meanwhile.
   int hold_served = 0;
   int hold_left   = 0;

   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
   end

   // ---------------------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------------------

   // one input item; may idle first, then holds until accepted and leaves valid high
   task automatic send_item(input logic [7:0] data, input logic region_end);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid      <= 1'b0;
         req_data_byte  <= 8'($urandom);   // junk while idle
         req_region_end <= 1'($urandom);
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= data;
      req_region_end <= region_end;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // stop sending and let every expected result come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // csr_valid stays high across back-to-back writes; caller lowers it
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // writes every register; bits above each field's width carry junk
   task automatic set_config(input logic [63:0] pattern_low, input logic [63:0] pattern_high,
                             input logic [15:0] must_match, input logic [PLEN_W-1:0] len,
                             input logic [CAPACITY_W-1:0] capacity,
                             input logic [MODE_W-1:0] mode);
      logic [63:0] junk;
      junk = {$urandom(), $urandom()};
      write_reg(REG_PATTERN_LOW,  pattern_low);
      write_reg(REG_PATTERN_HIGH, pattern_high);
      write_reg(REG_MUST_MATCH,   {junk[63:16], must_match});
      write_reg(REG_PATTERN_LEN,  {junk[63:PLEN_W], len});
      write_reg(REG_LIST_CAP,     {junk[63:CAPACITY_W], capacity});
      write_reg(REG_SEARCH_MODE,  {junk[63:MODE_W], mode});
      write_reg(REG_UNUSED,       junk);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------------
   // directed tests
   // ---------------------------------------------------------------------------------

   // reset config: one zero byte, all must match, capacity 0 so nothing fits
   task automatic test_reset_defaults();
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b1);
   endtask

   // four-byte pattern 'x' FF 00 'x' with bytes 1 and 3 wildcarded, both compares;
   // the first position hits both ways, the second only the masked way
   task automatic test_masked_and_exact();
      wait_drained();
      set_config(64'h0000_0000_7800_FF78, 64'h0, 16'hFFF5, 5'd4, 16'd1, MODE_BOTH);
      send_item(8'h78, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'h78, 1'b0);
      send_item(8'h78, 1'b0);
      send_item(8'h11, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'h55, 1'b1);
   endtask

   // mode code 3 acts as both; length 0 acts as 1; last item gives three results
   task automatic test_mode_three_zero_length();
      wait_drained();
      set_config(64'h78, '1, 16'hFFFF, 5'd0, 16'hFFFF, MODE_BOTH_ALT);
      send_item(8'h78, 1'b0);
      send_item(8'h78, 1'b1);
   endtask

   // length above the window clamps to 16; a region shorter than that gives only a total
   task automatic test_long_pattern_short_region();
      wait_drained();
      set_config('1, '1, 16'hFFFF, 5'd20, 16'd0, MODE_EXACT);
      send_item(8'hFF, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'hFF, 1'b1);
   endtask

   // shrink the pattern between two items of one region
   task automatic test_length_change();
      wait_drained();
      set_config(64'h7878, 64'h0, 16'hFFFF, 5'd2, 16'd2, MODE_MASKED);
      send_item(8'h78, 1'b0);
      send_item(8'h78, 1'b0);
      wait_drained();
      set_config(64'h7878, 64'h0, 16'hFFFF, 5'd1, 16'd2, MODE_MASKED);
      send_item(8'h78, 1'b1);
   endtask

   // ---------------------------------------------------------------------------------
   // random traffic
   // ---------------------------------------------------------------------------------

   // Random configs, three regions each. Regions mostly carry copies of the pattern
   // (wildcard bytes scrambled) among bytes drawn from the pattern and from noise.
   task automatic test_random_traffic(input int idle, input int stall, input int budget);
      int                    first_item;
      int                    region_len;
      int                    pos;
      int                    eff_len;
      logic [63:0]           lo;
      logic [63:0]           hi;
      logic [15:0]           must;
      logic [PLEN_W-1:0]     len;
      logic [CAPACITY_W-1:0] capacity;
      logic [127:0]          pattern;
      logic [7:0]            b;

      first_item = items_sent;
      while (items_sent - first_item < budget) begin
         wait_drained();
         idle_pct  = idle;
         stall_pct <= stall;
         lo = {$urandom(), $urandom()};
         hi = {$urandom(), $urandom()};
         case ($urandom_range(9))
            0:       len = 5'd0;
            1:       len = 5'd16;
            2:       len = 5'($urandom_range(17, 31));
            3:       len = 5'($urandom_range(5, 15));
            default: len = 5'($urandom_range(1, 4));
         endcase
         case ($urandom_range(3))
            0:       must = 16'hFFFF;
            1:       must = 16'h0000;
            default: must = 16'($urandom);
         endcase
         case ($urandom_range(3))
            0:       capacity = '0;
            1:       capacity = '1;
            default: capacity = CAPACITY_W'($urandom_range(1, 4));
         endcase
         set_config(lo, hi, must, len, capacity, MODE_W'($urandom_range(3)));

         eff_len = (len == 0) ? 1 : ((len > PATTERN_BYTES) ? PATTERN_BYTES : int'(len));
         pattern = {hi, lo};
         for (int r = 0; r < 3 && items_sent - first_item < budget; r++) begin
            region_len = $urandom_range(1, eff_len + 8);
            pos = 0;
            while (pos < region_len) begin
               if ($urandom_range(1) == 0 && pos + eff_len <= region_len) begin
                  for (int j = 0; j < eff_len; j++) begin
                     b = pattern[8*j +: 8];
                     if (!must[j] && $urandom_range(1) == 0) b = 8'($urandom);
                     pos++;
                     send_item(b, pos == region_len);
                  end
               end else begin
                  b = ($urandom_range(3) == 0) ? 8'($urandom)
                                                : pattern[8*$urandom_range(eff_len - 1) +: 8];
                  pos++;
                  send_item(b, pos == region_len);
               end
            end
         end
      end
   endtask

   // Long output hold while the sender streams items: the block fills and stalls its
   // input. A single wildcard byte makes every item a masked hit; 'x' bytes hit exact too.
   task automatic test_output_backpressure();
      wait_drained();
      idle_pct  = 0;
      stall_pct <= 0;
      set_config(64'h78, 64'h0, 16'h0000, 5'd1, 16'd8, MODE_BOTH);
      hold_requests <= hold_requests + 1;
      for (int k = 0; k < 40; k++) send_item(k[0] ? 8'h78 : 8'($urandom), k == 39);
      // sender waits here until every result has come out
      wait_drained();
   endtask

   // ---------------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_masked_and_exact();
      test_mode_three_zero_length();
      test_long_pattern_short_region();
      test_length_change();

      test_random_traffic(0, 0, 30);      // no idling
      test_random_traffic(59, 0, 30);     // sender gaps
      test_random_traffic(0, 59, 30);     // receiver stalls
      test_random_traffic(36, 36, 35);    // both
      test_output_backpressure();

      wait_drained();
      mismatch_count += pending_results.size();

      $display("Scanned %0d input items; checked %0d results (%0d matches, %0d totals).",
               items_sent, results_checked, match_results_seen, done_results_seen);
      $display("Covered masked/exact/both modes, clamped lengths, idle mixes, long hold.");
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #2ms;
      $display("simulation failed");
      $finish;
   end

endmodule

// ----- masked_byte_pattern_scanner_top.f -----
+incdir+rtl/core
rtl/core/mbps_pkg.sv
rtl/core/mbps_cell.sv
rtl/core/mbps_emit.sv
rtl/core/masked_byte_pattern_scanner_top.sv
rtl/core/mbps_checker.sv
bench/tb_masked_byte_pattern_scanner_top.sv
